FILE: hdl/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types, permutation tables and single precision helpers for the
// 4x4 tile multiplier.
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int TILE_N = 16;

    typedef logic [31:0] word_t;

    // gather index into b per pass and lane
    localparam logic [3:0] GATHER [4][16] = '{
        '{4'd0, 4'd5, 4'd10, 4'd15, 4'd1, 4'd6, 4'd11, 4'd12,
          4'd2, 4'd7, 4'd8, 4'd13, 4'd3, 4'd4, 4'd9, 4'd14},
        '{4'd1, 4'd6, 4'd11, 4'd12, 4'd2, 4'd7, 4'd8, 4'd13,
          4'd3, 4'd4, 4'd9, 4'd14, 4'd0, 4'd5, 4'd10, 4'd15},
        '{4'd2, 4'd7, 4'd8, 4'd13, 4'd3, 4'd4, 4'd9, 4'd14,
          4'd0, 4'd5, 4'd10, 4'd15, 4'd1, 4'd6, 4'd11, 4'd12},
        '{4'd3, 4'd4, 4'd9, 4'd14, 4'd0, 4'd5, 4'd10, 4'd15,
          4'd1, 4'd6, 4'd11, 4'd12, 4'd2, 4'd7, 4'd8, 4'd13}
    };

    // destination element of c per pass and lane
    localparam logic [3:0] SCATTER [4][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4,
          4'd10, 4'd11, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14},
        '{4'd1, 4'd2, 4'd3, 4'd0, 4'd6, 4'd7, 4'd4, 4'd5,
          4'd11, 4'd8, 4'd9, 4'd10, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd2, 4'd3, 4'd0, 4'd1, 4'd7, 4'd4, 4'd5, 4'd6,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15, 4'd12},
        '{4'd3, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd9, 4'd10, 4'd11, 4'd8, 4'd14, 4'd15, 4'd12, 4'd13}
    };

    localparam word_t QNAN    = 32'h7FC0_0000;
    localparam logic  MODE_FP = 1'b0;

    // full tile handed from front to back
    typedef struct packed {
        logic              full;
        logic              mode;
        logic [15:0][31:0] a;
        logic [15:0][31:0] b;
    } tile_q_t;

    // unrounded operation result: value = sig * 2^x, or a finished word
    typedef struct packed {
        logic        special;
        logic [31:0] spec_val;
        logic        sign;
        logic [49:0] sig;
        logic [11:0] x;
    } raw_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } mmt_state_t;

    function automatic logic [5:0] lzc50(logic [49:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd50;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(49 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic word_t fp_round_pack(logic sign, logic [49:0] sig, logic [11:0] x);
        logic [5:0]         lz;
        logic [49:0]        norm;
        logic signed [11:0] be;
        logic signed [11:0] ext;
        logic [6:0]         sh;
        logic [49:0]        q;
        logic [49:0]        rbv;
        logic               rb;
        logic               st;
        logic [24:0]        rnd;
        logic [11:0]        bec;
        logic [35:0]        pk;
        word_t              res;
        lz   = lzc50(sig);
        norm = sig << lz;
        be   = $signed(x) - $signed({6'd0, lz}) + 12'sd176;
        ext  = 12'sd1 - be;
        if (be >= 12'sd1)
            sh = 7'd26;
        else if (ext > 12'sd25)
            sh = 7'd51;
        else
            sh = 7'd26 + ext[6:0];
        q   = norm >> sh;
        rbv = norm >> (sh - 7'd1);
        rb  = rbv[0];
        st  = |(norm & ((50'd1 << (sh - 7'd1)) - 50'd1));
        rnd = q[24:0] + {24'd0, rb & (st | q[0])};
        bec = (be >= 12'sd1) ? be : 12'd1;
        pk  = (36'(bec - 12'd1) << 23) + {11'd0, rnd};
        if (pk >= 36'h0_7F80_0000)
            res = {sign, 31'h7F80_0000};
        else
            res = {sign, pk[30:0]};
        return res;
    endfunction

    function automatic raw_t fp_mul_pre(word_t a, word_t b);
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic        na;
        logic        nb;
        logic        ia;
        logic        ib;
        logic        za;
        logic        zb;
        logic        sg;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] prod;
        raw_t        r;
        ea = a[30:23];
        eb = b[30:23];
        na = (ea == 8'hFF) && (a[22:0] != 23'd0);
        nb = (eb == 8'hFF) && (b[22:0] != 23'd0);
        ia = (ea == 8'hFF) && (a[22:0] == 23'd0);
        ib = (eb == 8'hFF) && (b[22:0] == 23'd0);
        za = (a[30:0] == 31'd0);
        zb = (b[30:0] == 31'd0);
        sg = a[31] ^ b[31];
        ma = {ea != 8'd0, a[22:0]};
        mb = {eb != 8'd0, b[22:0]};
        prod = 48'(ma) * 48'(mb);
        r.special  = 1'b1;
        r.spec_val = QNAN;
        r.sign     = sg;
        r.sig      = {2'b00, prod};
        r.x        = 12'({4'd0, (ea == 8'd0) ? 8'd1 : ea})
                   + 12'({4'd0, (eb == 8'd0) ? 8'd1 : eb}) - 12'd300;
        if (na || nb || (ia && zb) || (ib && za))
            r.spec_val = QNAN;
        else if (ia || ib)
            r.spec_val = {sg, 31'h7F80_0000};
        else if (za || zb)
            r.spec_val = {sg, 31'd0};
        else
            r.special = 1'b0;
        return r;
    endfunction

    function automatic raw_t fp_add_pre(word_t x, word_t y);
        logic        nx;
        logic        ny;
        logic        ix;
        logic        iy;
        logic        zx;
        logic        zy;
        word_t       wl;
        word_t       ws;
        logic [7:0]  el;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [26:0] sl;
        logic [26:0] ss;
        logic [26:0] ssh;
        logic        stk;
        logic [27:0] sum;
        raw_t        r;
        nx = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        ny = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        ix = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        iy = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        zx = (x[30:0] == 31'd0);
        zy = (y[30:0] == 31'd0);
        if (x[30:0] >= y[30:0]) begin
            wl = x;
            ws = y;
        end else begin
            wl = y;
            ws = x;
        end
        el  = (wl[30:23] == 8'd0) ? 8'd1 : wl[30:23];
        es  = (ws[30:23] == 8'd0) ? 8'd1 : ws[30:23];
        d   = el - es;
        sl  = {wl[30:23] != 8'd0, wl[22:0], 3'b000};
        ss  = {ws[30:23] != 8'd0, ws[22:0], 3'b000};
        if (d >= 8'd27) begin
            ssh = 27'd0;
            stk = 1'b1;
        end else begin
            ssh = ss >> d;
            stk = |(ss & ((27'd1 << d) - 27'd1));
        end
        ssh[0] = ssh[0] | stk;
        if (wl[31] == ws[31])
            sum = {1'b0, sl} + {1'b0, ssh};
        else
            sum = {1'b0, sl} - {1'b0, ssh};
        r.special  = 1'b1;
        r.spec_val = 32'd0;
        r.sign     = wl[31];
        r.sig      = {22'd0, sum};
        r.x        = 12'({4'd0, el}) - 12'd153;
        if (nx || ny || (ix && iy && (x[31] != y[31])))
            r.spec_val = QNAN;
        else if (ix)
            r.spec_val = x;
        else if (iy)
            r.spec_val = y;
        else if (zx && zy)
            r.spec_val = {x[31] & y[31], 31'd0};
        else if (zx)
            r.spec_val = y;
        else if (zy)
            r.spec_val = x;
        else if (sum == 28'd0)
            r.spec_val = 32'd0;
        else
            r.special = 1'b0;
        return r;
    endfunction

endpackage

FILE: hdl/mmt_front.sv
// ----------------------------------------------------------------------------
// mmt_front
// Row loader: takes one row of a and b per word, holds the mode register
// and hands each complete tile to a one-slot queue for the back end.
// ----------------------------------------------------------------------------
module mmt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [31:0]      a_elem0,
    input  logic [31:0]      a_elem1,
    input  logic [31:0]      a_elem2,
    input  logic [31:0]      a_elem3,
    input  logic [31:0]      b_elem0,
    input  logic [31:0]      b_elem1,
    input  logic [31:0]      b_elem2,
    input  logic [31:0]      b_elem3,
    input  logic             q_release,
    output mmt_pkg::tile_q_t tile_q
);
    import mmt_pkg::*;

    logic              number_mode_reg;
    logic [1:0]        rows_loaded_reg;
    logic [11:0][31:0] a_load_reg;
    logic [11:0][31:0] b_load_reg;
    logic [15:0][31:0] q_a_reg;
    logic [15:0][31:0] q_b_reg;
    logic              q_mode_reg;
    logic              q_full_reg;
    logic              accept;
    logic [3:0][31:0]  a_row;
    logic [3:0][31:0]  b_row;

    assign a_row    = {a_elem3, a_elem2, a_elem1, a_elem0};
    assign b_row    = {b_elem3, b_elem2, b_elem1, b_elem0};
    assign in_stall = (rows_loaded_reg == 2'd3) && q_full_reg;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mode_reg <= MODE_FP;
            rows_loaded_reg <= 2'd0;
            q_full_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                number_mode_reg <= cfg_wr_data;
            if (accept)
                rows_loaded_reg <= rows_loaded_reg + 2'd1;
            if (accept && rows_loaded_reg == 2'd3)
                q_full_reg <= 1'b1;
            else if (q_release)
                q_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (rows_loaded_reg == 2'd3)
            begin
                q_a_reg    <= {a_row, a_load_reg};
                q_b_reg    <= {b_row, b_load_reg};
                q_mode_reg <= number_mode_reg;
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    a_load_reg[{rows_loaded_reg, 2'(k)}] <= a_row[k];
                    b_load_reg[{rows_loaded_reg, 2'(k)}] <= b_row[k];
                end
            end
        end
    end

    assign tile_q.full = q_full_reg;
    assign tile_q.mode = q_mode_reg;
    assign tile_q.a    = q_a_reg;
    assign tile_q.b    = q_b_reg;

endmodule

FILE: hdl/mmt_back.sv
// ----------------------------------------------------------------------------
// mmt_back
// Multiply-accumulate engine: walks the four passes of sixteen lanes through
// one pipelined multiply and add, then returns the four rows of c.
// ----------------------------------------------------------------------------
module mmt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mmt_pkg::tile_q_t tile_q,
    output logic             q_release,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [31:0]      c_elem0,
    output logic [31:0]      c_elem1,
    output logic [31:0]      c_elem2,
    output logic [31:0]      c_elem3,
    output logic [1:0]       row_number,
    output logic             last_row
);
    import mmt_pkg::*;

    mmt_state_t  state_reg;
    mmt_state_t  state_next;
    logic [5:0]  step_reg;
    logic [1:0]  row_reg;
    logic        mode_reg;
    logic        issue;
    logic        clear_acc;
    logic        emit_done;
    logic        pipe_busy;

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    word_t       a1_reg;
    word_t       b1_reg;
    logic [3:0]  d1_reg;
    raw_t        raw2_reg;
    logic [3:0]  d2_reg;
    word_t       prod3_reg;
    logic [3:0]  d3_reg;
    raw_t        raw4_reg;
    logic [3:0]  d4_reg;

    word_t       acc_reg [TILE_N];
    raw_t        mul_raw;
    raw_t        add_raw;
    word_t       prod_w;
    word_t       res_w;
    word_t       c_row [4];

    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign emit_done = out_valid && !out_stall && (row_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (tile_q.full) state_next = ST_RUN;
            ST_RUN:   if (step_reg == 6'd63) state_next = ST_DRAIN;
            ST_DRAIN: if (!pipe_busy) state_next = ST_EMIT;
            ST_EMIT:  if (emit_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        issue     = 1'b0;
        clear_acc = 1'b0;
        q_release = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:  clear_acc = tile_q.full;
            ST_RUN:
            begin
                issue     = 1'b1;
                q_release = (step_reg == 6'd63);
            end
            ST_DRAIN: ;
            ST_EMIT:  out_valid = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 6'd0;
            row_reg   <= 2'd0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_acc)
                step_reg <= 6'd0;
            else if (issue)
                step_reg <= step_reg + 6'd1;
            if (clear_acc)
                row_reg <= 2'd0;
            else if (out_valid && !out_stall)
                row_reg <= row_reg + 2'd1;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // multiply front half, int mode finishes here
    always_comb
    begin
        mul_raw = fp_mul_pre(a1_reg, b1_reg);
        if (mode_reg != MODE_FP)
        begin
            mul_raw.special  = 1'b1;
            mul_raw.spec_val = a1_reg * b1_reg;
        end
    end

    assign prod_w = raw2_reg.special ? raw2_reg.spec_val
                  : fp_round_pack(raw2_reg.sign, raw2_reg.sig, raw2_reg.x);

    always_comb
    begin
        add_raw = fp_add_pre(acc_reg[d3_reg], prod3_reg);
        if (mode_reg != MODE_FP)
        begin
            add_raw.special  = 1'b1;
            add_raw.spec_val = acc_reg[d3_reg] + prod3_reg;
        end
    end

    assign res_w = raw4_reg.special ? raw4_reg.spec_val
                 : fp_round_pack(raw4_reg.sign, raw4_reg.sig, raw4_reg.x);

    always_ff @(posedge clk)
    begin
        if (clear_acc)
            mode_reg <= tile_q.mode;
        a1_reg    <= tile_q.a[step_reg[3:0]];
        b1_reg    <= tile_q.b[GATHER[step_reg[5:4]][step_reg[3:0]]];
        d1_reg    <= SCATTER[step_reg[5:4]][step_reg[3:0]];
        raw2_reg  <= mul_raw;
        d2_reg    <= d1_reg;
        prod3_reg <= prod_w;
        d3_reg    <= d2_reg;
        raw4_reg  <= add_raw;
        d4_reg    <= d3_reg;
        if (clear_acc)
        begin
            for (int i = 0; i < TILE_N; i++)
                acc_reg[i] <= 32'd0;
        end
        else if (v4_reg)
            acc_reg[d4_reg] <= res_w;
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            c_row[k] = acc_reg[{row_reg, 2'(k)}];
            if (mode_reg == MODE_FP && c_row[k][30:23] == 8'hFF && c_row[k][22:0] != 23'd0)
                c_row[k] = QNAN;
        end
    end

    assign c_elem0    = c_row[0];
    assign c_elem1    = c_row[1];
    assign c_elem2    = c_row[2];
    assign c_elem3    = c_row[3];
    assign row_number = row_reg;
    assign last_row   = (row_reg == 2'd3);

endmodule

FILE: hdl/tile_4x4_matrix_multiply.sv
// ----------------------------------------------------------------------------
// tile_4x4_matrix_multiply
// 4x4 tile product c = a * b in single precision float or 32-bit integer.
// ----------------------------------------------------------------------------
// Each input word loads one row of a and b, one word per cycle while in_stall
// is low. The fourth row moves the tile into a one-slot queue; the back end
// picks it up from the idle state, runs 64 lane steps through a single
// pipelined multiply and add (one step per cycle), waits for the pipeline to
// drain and returns four row words, holding each while the output stalls.
// The shared multiply-add pipeline limits throughput; rows of the next tile
// load meanwhile and the input stalls only on a fourth row while the queue
// slot is still taken.
module tile_4x4_matrix_multiply (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] a_elem0,
    input  logic [31:0] a_elem1,
    input  logic [31:0] a_elem2,
    input  logic [31:0] a_elem3,
    input  logic [31:0] b_elem0,
    input  logic [31:0] b_elem1,
    input  logic [31:0] b_elem2,
    input  logic [31:0] b_elem3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] c_elem0,
    output logic [31:0] c_elem1,
    output logic [31:0] c_elem2,
    output logic [31:0] c_elem3,
    output logic [1:0]  row_number,
    output logic        last_row
);
    import mmt_pkg::*;

    tile_q_t tile_q;
    logic    q_release;

    mmt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_elem0     (a_elem0),
        .a_elem1     (a_elem1),
        .a_elem2     (a_elem2),
        .a_elem3     (a_elem3),
        .b_elem0     (b_elem0),
        .b_elem1     (b_elem1),
        .b_elem2     (b_elem2),
        .b_elem3     (b_elem3),
        .q_release   (q_release),
        .tile_q      (tile_q)
    );

    mmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tile_q     (tile_q),
        .q_release  (q_release),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .c_elem0    (c_elem0),
        .c_elem1    (c_elem1),
        .c_elem2    (c_elem2),
        .c_elem3    (c_elem3),
        .row_number (row_number),
        .last_row   (last_row)
    );

    // input only stalls against a full queue slot
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> tile_q.full)
        else $error("input stalled with empty queue slot");

    a_release_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_release |-> tile_q.full)
        else $error("queue released while empty");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_release |=> !tile_q.full)
        else $error("queue slot still full after release");

    a_no_emit_while_queued_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_release |-> !out_valid)
        else $error("output word during tile walk");

endmodule
